FILE: rtl/nal_sc_pkg.sv
package nal_sc_pkg;

  localparam int unsigned HoldDepth  = 4;
  localparam int unsigned HoldIdxW   = 2;
  localparam int unsigned HoldCntW   = 3;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueuePtrW  = 3;
  localparam int unsigned QueueCntW  = 4;

  typedef logic [7:0] byte_t;

  localparam byte_t ByteZero = 8'h00;
  localparam byte_t ByteOne  = 8'h01;
  localparam byte_t ByteEpb  = 8'h03;

  typedef enum logic [1:0] {
    ZR_NONE,
    ZR_ONE,
    ZR_MANY
  } zero_run_e;

  typedef enum logic {
    KIND_BYTE,
    KIND_EOS
  } kind_e;

  typedef struct packed {
    byte_t data;
    logic  last;
  } result_t;

endpackage

FILE: rtl/nal_start_code_splitter_core.sv
// Start code splitter: takes an elementary video byte stream one word per cycle and
// returns the units found between 00 00 01 start codes, each unit's final byte marked
// with tlast. Bytes before the first start code are discarded. The zero bytes of the
// closing start code are trimmed, plus one more trailing zero unless it follows 0x03.
// A word with tuser set flushes the held tail of the current unit untrimmed and
// returns the block to its idle state; with nothing held it changes nothing. Results
// are registered into an eight-entry output queue, from which they leave in order.
// The input takes one word per cycle while at most four results are queued; a flush
// or a start code queues up to four or two results at once, so the input can stall
// after one of them until the output has drained the queue back to four results.
module nal_start_code_splitter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] kind
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] unit_byte
  output logic       m_axis_tlast_o    // unit_last
);

  nal_sc_pkg::zero_run_e zero_run_q, zero_run_d;
  logic                  capturing_q, capturing_d;
  nal_sc_pkg::byte_t     hold_q [nal_sc_pkg::HoldDepth];
  nal_sc_pkg::byte_t     hold_d [nal_sc_pkg::HoldDepth];
  logic [nal_sc_pkg::HoldCntW-1:0] hold_cnt_q, hold_cnt_d;

  nal_sc_pkg::result_t             batch [nal_sc_pkg::HoldDepth];
  logic [nal_sc_pkg::HoldCntW-1:0] batch_n;
  logic [nal_sc_pkg::HoldCntW-1:0] keep;

  nal_sc_pkg::result_t              queue_q [nal_sc_pkg::QueueDepth];
  logic [nal_sc_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [nal_sc_pkg::QueueCntW-1:0] cnt_q;

  logic in_accept;
  logic pop;
  nal_sc_pkg::byte_t in_byte;

  assign in_byte         = s_axis_tdata_i;
  assign s_axis_tready_o = cnt_q <= nal_sc_pkg::QueueCntW'(nal_sc_pkg::QueueDepth
                                                            - nal_sc_pkg::HoldDepth);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = cnt_q != '0;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = queue_q[rd_q].data;
  assign m_axis_tlast_o  = queue_q[rd_q].last;

  always_comb begin
    zero_run_d  = zero_run_q;
    capturing_d = capturing_q;
    hold_d      = hold_q;
    hold_cnt_d  = hold_cnt_q;
    batch_n     = '0;
    keep        = '0;
    for (int k = 0; k < nal_sc_pkg::HoldDepth; k++) begin
      batch[k].data = hold_q[k];
      batch[k].last = 1'b0;
    end

    if (in_accept) begin
      if (nal_sc_pkg::kind_e'(s_axis_tuser_i) == nal_sc_pkg::KIND_EOS) begin
        // flush whatever is held, untrimmed, and return to idle if anything was held
        if (hold_cnt_q != '0) begin
          batch_n = hold_cnt_q;
          for (int k = 0; k < nal_sc_pkg::HoldDepth; k++) begin
            batch[k].last = nal_sc_pkg::HoldCntW'(k + 1) == hold_cnt_q;
          end
          zero_run_d  = nal_sc_pkg::ZR_NONE;
          capturing_d = 1'b0;
          hold_cnt_d  = '0;
        end
      end else if (in_byte == nal_sc_pkg::ByteOne && zero_run_q == nal_sc_pkg::ZR_MANY) begin
        zero_run_d = nal_sc_pkg::ZR_NONE;
        if (!capturing_q) begin
          capturing_d = 1'b1;
        end else begin
          // drop the two start code zeros, and with four bytes held a third one unless it is escaped
          keep = (hold_cnt_q >= nal_sc_pkg::HoldCntW'(2)) ?
                 hold_cnt_q - nal_sc_pkg::HoldCntW'(2) : '0;
          if (keep == nal_sc_pkg::HoldCntW'(2) && hold_q[1] == nal_sc_pkg::ByteZero &&
              hold_q[0] != nal_sc_pkg::ByteEpb) begin
            keep = nal_sc_pkg::HoldCntW'(1);
          end
          batch_n = keep;
          for (int k = 0; k < nal_sc_pkg::HoldDepth; k++) begin
            batch[k].last = nal_sc_pkg::HoldCntW'(k + 1) == keep;
          end
          hold_cnt_d = '0;
        end
      end else begin
        if (in_byte == nal_sc_pkg::ByteZero) begin
          zero_run_d = (zero_run_q == nal_sc_pkg::ZR_NONE) ? nal_sc_pkg::ZR_ONE
                                                            : nal_sc_pkg::ZR_MANY;
        end else begin
          zero_run_d = nal_sc_pkg::ZR_NONE;
        end
        if (capturing_q) begin
          if (hold_cnt_q >= nal_sc_pkg::HoldCntW'(nal_sc_pkg::HoldDepth)) begin
            // window full: release the oldest byte and shift
            batch_n = nal_sc_pkg::HoldCntW'(1);
            for (int k = 0; k < nal_sc_pkg::HoldDepth - 1; k++) begin
              hold_d[k] = hold_q[k + 1];
            end
            hold_d[nal_sc_pkg::HoldDepth - 1] = in_byte;
          end else begin
            hold_d[hold_cnt_q[nal_sc_pkg::HoldIdxW-1:0]] = in_byte;
            hold_cnt_d = hold_cnt_q + nal_sc_pkg::HoldCntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q  <= nal_sc_pkg::ZR_NONE;
      capturing_q <= 1'b0;
      hold_cnt_q  <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      cnt_q       <= '0;
    end else begin
      zero_run_q  <= zero_run_d;
      capturing_q <= capturing_d;
      hold_cnt_q  <= hold_cnt_d;
      wr_q        <= wr_q + nal_sc_pkg::QueuePtrW'(batch_n);
      rd_q        <= rd_q + nal_sc_pkg::QueuePtrW'(pop);
      cnt_q       <= cnt_q + nal_sc_pkg::QueueCntW'(batch_n) - nal_sc_pkg::QueueCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    for (int k = 0; k < nal_sc_pkg::HoldDepth; k++) begin
      if (nal_sc_pkg::HoldCntW'(k) < batch_n) begin
        queue_q[wr_q + nal_sc_pkg::QueuePtrW'(k)] <= batch[k];
      end
    end
  end

endmodule

FILE: rtl/nal_sc_checker.sv
module nal_sc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // input back-pressure only while results are queued
  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output queue");

  // results only appear after an accepted input word
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("output word without a preceding input word");

endmodule

bind nal_start_code_splitter_core nal_sc_checker u_nal_sc_checker (.*);
